// ===== rtl/i2cee_pkg.sv =====
// i2cee_pkg: types and constants for the I2C EEPROM transfer sequencer.
// No dependencies; imported by the sequencer and its checker.
package i2cee_pkg;

    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_START_RES = 3'd2,
        OP_BYTE_DONE = 3'd3,
        OP_STOP_RES  = 3'd4,
        OP_TIMER     = 3'd5,
        OP_INIT      = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_START      = 3'd1,
        CMD_SEND       = 3'd2,
        CMD_RX_ACK     = 3'd3,
        CMD_RX_NACK    = 3'd4,
        CMD_STOP       = 3'd5,
        CMD_STOP_TIMER = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK     = 3'd0,
        STS_BUSY   = 3'd1,
        STS_BUS    = 3'd2,
        STS_START  = 3'd3,
        STS_NOACK  = 3'd4,
        STS_VERIFY = 3'd5,
        STS_RETRY  = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        ST_INIT        = 4'd0,
        ST_RESET_START = 4'd1,
        ST_RESET_STOP  = 4'd2,
        ST_IDLE        = 4'd3,
        ST_ERR_BUS     = 4'd4,
        ST_ERR_START   = 4'd5,
        ST_ERR_ACK     = 4'd6,
        ST_ERR_VERIFY  = 4'd7,
        ST_XF_START    = 4'd8,
        ST_XF_ADDR_HI  = 4'd9,
        ST_XF_ADDR_LO  = 4'd10,
        ST_RD_RESTART  = 4'd11,
        ST_RD_RX       = 4'd12,
        ST_WR_DATA     = 4'd13,
        ST_WR_WAIT     = 4'd14
    } t_state;

    typedef enum logic [1:0] {
        REG_KEY_AREA     = 2'd0,
        REG_MAIN_AREA    = 2'd1,
        REG_SERVICE_AREA = 2'd2,
        REG_SCRATCH_AREA = 2'd3
    } t_reg;

    localparam logic [7:0] ADDR_RESET = 8'hFF;
    localparam logic [7:0] ADDR_READ  = 8'hA1;
    localparam logic [7:0] ADDR_WRITE = 8'hA0;

endpackage

// ===== rtl/i2c_eeprom_transfer_sequencer.sv =====
// Channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------------------
// input     | i_in_valid  / o_in_stall  | operation, start_ok, ack, rx_byte, bus_free,
//           |                           | area, length, write_byte
// output    | o_out_valid / i_out_stall | bus_command, bus_byte, read_*, status_*,
//           |                           | next_index
// config    | i_cfg_we (no handshake)   | i_cfg_index, i_cfg_data
//
// Every event taken gives one result beat: it is held in the input register, then
// passes through the sequencer decision into the result register.
// One event per cycle unless the result stalls; state updates in the second stage.
// Reset (synchronous, active low) puts the sequencer in its init state and empties
// both stages. A stalled result holds the result register; the input stage keeps
// accepting until it also holds an event.
//
// Depends on i2cee_pkg.
module i2c_eeprom_transfer_sequencer #(
    parameter int PAGE_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic        i_start_ok,
    input  logic        i_ack,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_bus_free,
    input  logic [1:0]  i_area,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_write_byte,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_bus_command,
    output logic [7:0]  o_bus_byte,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic [15:0] o_read_index,
    output logic        o_status_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_next_index
);
    import i2cee_pkg::*;

    localparam int PAGE_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_BYTES - 1);
    localparam logic [15:0] PAGE_STEP = 16'(PAGE_BYTES);

    // area base registers
    logic [15:0] r_area_base [4];

    // input stage
    logic        r_in_valid;
    logic [2:0]  r_op;
    logic        r_start_ok;
    logic        r_ack;
    logic [7:0]  r_rx;
    logic        r_bus_free;
    logic [1:0]  r_area;
    logic [15:0] r_len_in;
    logic [7:0]  r_wbyte;

    // sequencer state
    t_state      r_state,  n_state;
    logic [15:0] r_count,  n_count;
    logic [15:0] r_length, n_length;
    logic [15:0] r_addr,   n_addr;
    logic [7:0]  r_last,   n_last;
    logic        r_is_wr,  n_is_wr;
    logic [PAGE_W-1:0] r_page, n_page;

    // result stage
    logic        r_out_valid;
    t_cmd        r_cmd,     n_cmd;
    logic [7:0]  r_bbyte,   n_bbyte;
    logic        r_rvalid,  n_rvalid;
    logic [7:0]  r_rbyte,   n_rbyte;
    logic [15:0] r_rindex,  n_rindex;
    logic        r_svalid,  n_svalid;
    t_status     r_status,  n_status;
    logic [15:0] r_nindex,  n_nindex;

    logic        out_free;
    logic        fire;
    logic [15:0] count_inc;
    logic [15:0] count_inc2;
    logic        page_hit;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign count_inc  = r_count + 16'd1;
    assign count_inc2 = r_count + 16'd2;
    assign page_hit   = (r_page == PAGE_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_area_base[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_area_base[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op       <= i_operation;
            r_start_ok <= i_start_ok;
            r_ack      <= i_ack;
            r_rx       <= i_rx_byte;
            r_bus_free <= i_bus_free;
            r_area     <= i_area;
            r_len_in   <= i_length;
            r_wbyte    <= i_write_byte;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_length = r_length;
        n_addr   = r_addr;
        n_last   = r_last;
        n_is_wr  = r_is_wr;
        n_page   = r_page;
        n_cmd    = CMD_NONE;
        n_bbyte  = '0;
        n_rvalid = 1'b0;
        n_rbyte  = '0;
        n_rindex = '0;
        n_svalid = 1'b0;
        n_status = STS_OK;

        case (r_op)
            OP_READ, OP_WRITE: begin
                n_svalid = 1'b1;
                case (r_state)
                    ST_INIT, ST_RESET_START, ST_RESET_STOP: n_status = STS_RETRY;
                    ST_IDLE: begin
                        n_svalid = 1'b0;
                        n_length = r_len_in;
                        n_count  = '0;
                        n_page   = '0;
                        n_addr   = r_area_base[r_area];
                        n_is_wr  = (r_op == OP_WRITE);
                        n_state  = ST_XF_START;
                        n_cmd    = CMD_START;
                        n_bbyte  = ADDR_WRITE;
                    end
                    ST_ERR_BUS:    n_status = STS_BUS;
                    ST_ERR_START:  n_status = STS_START;
                    ST_ERR_ACK:    n_status = STS_NOACK;
                    ST_ERR_VERIFY: n_status = STS_VERIFY;
                    default:       n_status = STS_BUSY;
                endcase
            end
            OP_START_RES: begin
                if (!r_start_ok && (r_state == ST_RESET_START || r_state == ST_XF_START ||
                                    r_state == ST_RD_RESTART)) begin
                    n_state  = ST_ERR_START;
                    n_svalid = 1'b1;
                    n_status = STS_START;
                end
            end
            OP_BYTE_DONE: begin
                case (r_state)
                    ST_RESET_START: begin
                        n_state = ST_RESET_STOP;
                        n_cmd   = CMD_STOP;
                    end
                    ST_XF_START, ST_XF_ADDR_HI, ST_XF_ADDR_LO, ST_RD_RESTART,
                    ST_WR_DATA: begin
                        if (!r_ack) begin
                            n_state  = ST_ERR_ACK;
                            n_svalid = 1'b1;
                            n_status = STS_NOACK;
                        end else begin
                            case (r_state)
                                ST_XF_START: begin
                                    n_state = ST_XF_ADDR_HI;
                                    n_cmd   = CMD_SEND;
                                    n_bbyte = r_addr[15:8];
                                end
                                ST_XF_ADDR_HI: begin
                                    n_state = ST_XF_ADDR_LO;
                                    n_cmd   = CMD_SEND;
                                    n_bbyte = r_addr[7:0];
                                end
                                ST_XF_ADDR_LO: begin
                                    if (r_is_wr) begin
                                        n_state = ST_WR_DATA;
                                        n_last  = r_wbyte;
                                        n_cmd   = CMD_SEND;
                                        n_bbyte = r_wbyte;
                                    end else begin
                                        n_state = ST_RD_RESTART;
                                        n_cmd   = CMD_START;
                                        n_bbyte = ADDR_READ;
                                    end
                                end
                                ST_RD_RESTART: begin
                                    n_state = ST_RD_RX;
                                    n_cmd   = (count_inc == r_length) ? CMD_RX_NACK
                                                                      : CMD_RX_ACK;
                                end
                                default: begin
                                    // write data: readback must match the byte sent
                                    if (r_rx != r_last) begin
                                        n_state  = ST_ERR_VERIFY;
                                        n_svalid = 1'b1;
                                        n_status = STS_VERIFY;
                                    end else begin
                                        n_count = count_inc;
                                        n_page  = page_hit ? '0 : r_page + PAGE_W'(1);
                                        if (count_inc == r_length || page_hit) begin
                                            n_state = ST_WR_WAIT;
                                            n_cmd   = CMD_STOP_TIMER;
                                        end else begin
                                            n_last  = r_wbyte;
                                            n_cmd   = CMD_SEND;
                                            n_bbyte = r_wbyte;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                    ST_RD_RX: begin
                        n_rvalid = 1'b1;
                        n_rbyte  = r_rx;
                        n_rindex = r_count;
                        n_count  = count_inc;
                        if (count_inc == r_length) begin
                            n_state  = ST_IDLE;
                            n_cmd    = CMD_STOP;
                            n_svalid = 1'b1;
                            n_status = STS_OK;
                        end else begin
                            // last byte gets the NACK
                            n_cmd = (count_inc2 == r_length) ? CMD_RX_NACK : CMD_RX_ACK;
                        end
                    end
                    default: ;
                endcase
            end
            OP_STOP_RES: begin
                if (r_state == ST_RESET_STOP) begin
                    if (r_bus_free) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state  = ST_ERR_BUS;
                        n_svalid = 1'b1;
                        n_status = STS_BUS;
                    end
                end
            end
            OP_TIMER: begin
                if (r_state == ST_WR_WAIT) begin
                    if (r_count == r_length) begin
                        n_state  = ST_IDLE;
                        n_cmd    = CMD_STOP;
                        n_svalid = 1'b1;
                        n_status = STS_OK;
                    end else begin
                        n_addr  = r_addr + PAGE_STEP;
                        n_state = ST_XF_START;
                        n_cmd   = CMD_START;
                        n_bbyte = ADDR_WRITE;
                    end
                end
            end
            OP_INIT: begin
                n_state = ST_RESET_START;
                n_cmd   = CMD_START;
                n_bbyte = ADDR_RESET;
            end
            default: ;
        endcase

        n_nindex = n_count + ((n_state == ST_WR_DATA) ? 16'd1 : 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_count  <= '0;
            r_length <= '0;
            r_addr   <= '0;
            r_last   <= '0;
            r_is_wr  <= 1'b0;
            r_page   <= '0;
        end else if (fire) begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_length <= n_length;
            r_addr   <= n_addr;
            r_last   <= n_last;
            r_is_wr  <= n_is_wr;
            r_page   <= n_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cmd    <= n_cmd;
            r_bbyte  <= n_bbyte;
            r_rvalid <= n_rvalid;
            r_rbyte  <= n_rbyte;
            r_rindex <= n_rindex;
            r_svalid <= n_svalid;
            r_status <= n_status;
            r_nindex <= n_nindex;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bus_command  = r_cmd;
    assign o_bus_byte     = r_bbyte;
    assign o_read_valid   = r_rvalid;
    assign o_read_byte    = r_rbyte;
    assign o_read_index   = r_rindex;
    assign o_status_valid = r_svalid;
    assign o_status       = r_status;
    assign o_next_index   = r_nindex;

endmodule

// ===== rtl/i2cee_checker.sv =====
// i2cee_port_checker: port-level assertions for the I2C EEPROM transfer sequencer,
// with the bind that attaches it to the top level. Depends on i2cee_pkg.
module i2cee_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_bus_command,
    input logic        o_read_valid,
    input logic [7:0]  o_read_byte,
    input logic [15:0] o_read_index,
    input logic        o_status_valid,
    input logic [2:0]  o_status
);
    import i2cee_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bus_command)
            && $stable(o_read_byte) && $stable(o_status))
        else $error("result beat changed under stall");

    // a received byte only comes with the next receive or the final stop
    a_read_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> o_bus_command == CMD_RX_ACK
            || o_bus_command == CMD_RX_NACK || o_bus_command == CMD_STOP)
        else $error("read byte without receive or stop");

    // successful completion always closes the bus
    a_ok_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_valid && o_status == STS_OK |-> o_bus_command == CMD_STOP)
        else $error("ok status without stop");

    // read fields are zero when no byte is reported
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_read_byte == 8'd0 && o_read_index == 16'd0)
        else $error("stale read fields");

    // no result beat straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind i2c_eeprom_transfer_sequencer i2cee_port_checker u_i2cee_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_bus_command  (o_bus_command),
    .o_read_valid   (o_read_valid),
    .o_read_byte    (o_read_byte),
    .o_read_index   (o_read_index),
    .o_status_valid (o_status_valid),
    .o_status       (o_status)
);

// ===== sim/i2cee_checker.sv =====
// i2cee_checker: watches the event and result channels of the EEPROM transfer sequencer,
// predicts every result beat from its own copy of the sequencer state and compares.
// Depends on i2cee_pkg.
module i2cee_checker #(
    parameter int PAGE_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_operation,
    input  logic        i_start_ok,
    input  logic        i_ack,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_bus_free,
    input  logic [1:0]  i_area,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_write_byte,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_bus_command,
    input  logic [7:0]  i_bus_byte,
    input  logic        i_read_valid,
    input  logic [7:0]  i_read_byte,
    input  logic [15:0] i_read_index,
    input  logic        i_status_valid,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_next_index,

    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2cee_pkg::*;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  bus_byte;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [15:0] read_index;
        logic        status_valid;
        t_status     status;
        logic [15:0] next_index;
    } t_bus_result;

    t_state      seq_state;
    logic [15:0] byte_count;
    logic [15:0] xfer_len;
    logic [15:0] ee_addr;
    logic [7:0]  last_sent;
    logic        writing;
    logic [15:0] area_base [4];

    t_bus_result bus_results_due [$];
    int          failures;
    int          beat_no;

    function automatic t_cmd receive_cmd();
        return (16'(byte_count + 16'd1) == xfer_len) ? CMD_RX_NACK : CMD_RX_ACK;
    endfunction

    function automatic t_bus_result sequence_event(
        input logic [2:0]  op,
        input logic        start_ok,
        input logic        ack,
        input logic [7:0]  rx,
        input logic        bus_free,
        input logic [1:0]  area,
        input logic [15:0] length,
        input logic [7:0]  wbyte
    );
        t_bus_result r;
        r = '0;
        case (op)
            OP_READ, OP_WRITE: begin
                r.status_valid = 1'b1;
                case (seq_state)
                    ST_INIT, ST_RESET_START, ST_RESET_STOP: r.status = STS_RETRY;
                    ST_IDLE: begin
                        r.status_valid = 1'b0;
                        xfer_len   = length;
                        byte_count = '0;
                        ee_addr    = area_base[area];
                        writing    = (op == OP_WRITE);
                        seq_state  = ST_XF_START;
                        r.cmd      = CMD_START;
                        r.bus_byte = ADDR_WRITE;
                    end
                    ST_ERR_BUS:    r.status = STS_BUS;
                    ST_ERR_START:  r.status = STS_START;
                    ST_ERR_ACK:    r.status = STS_NOACK;
                    ST_ERR_VERIFY: r.status = STS_VERIFY;
                    default:       r.status = STS_BUSY;
                endcase
            end
            OP_START_RES: begin
                if (!start_ok && (seq_state == ST_RESET_START || seq_state == ST_XF_START ||
                                  seq_state == ST_RD_RESTART)) begin
                    seq_state      = ST_ERR_START;
                    r.status_valid = 1'b1;
                    r.status       = STS_START;
                end
            end
            OP_BYTE_DONE: begin
                if (seq_state == ST_RESET_START) begin
                    seq_state = ST_RESET_STOP;
                    r.cmd     = CMD_STOP;
                end else if (!ack && (seq_state == ST_XF_START || seq_state == ST_XF_ADDR_HI ||
                                      seq_state == ST_XF_ADDR_LO ||
                                      seq_state == ST_RD_RESTART ||
                                      seq_state == ST_WR_DATA)) begin
                    // missing ack latches the error, no stop goes out
                    seq_state      = ST_ERR_ACK;
                    r.status_valid = 1'b1;
                    r.status       = STS_NOACK;
                end else begin
                    case (seq_state)
                        ST_XF_START: begin
                            seq_state  = ST_XF_ADDR_HI;
                            r.cmd      = CMD_SEND;
                            r.bus_byte = ee_addr[15:8];
                        end
                        ST_XF_ADDR_HI: begin
                            seq_state  = ST_XF_ADDR_LO;
                            r.cmd      = CMD_SEND;
                            r.bus_byte = ee_addr[7:0];
                        end
                        ST_XF_ADDR_LO: begin
                            if (writing) begin
                                seq_state  = ST_WR_DATA;
                                last_sent  = wbyte;
                                r.cmd      = CMD_SEND;
                                r.bus_byte = wbyte;
                            end else begin
                                seq_state  = ST_RD_RESTART;
                                r.cmd      = CMD_START;
                                r.bus_byte = ADDR_READ;
                            end
                        end
                        ST_RD_RESTART: begin
                            seq_state = ST_RD_RX;
                            r.cmd     = receive_cmd();
                        end
                        ST_RD_RX: begin
                            r.read_valid = 1'b1;
                            r.read_byte  = rx;
                            r.read_index = byte_count;
                            byte_count   = 16'(byte_count + 16'd1);
                            if (byte_count == xfer_len) begin
                                seq_state      = ST_IDLE;
                                r.cmd          = CMD_STOP;
                                r.status_valid = 1'b1;
                                r.status       = STS_OK;
                            end else begin
                                r.cmd = receive_cmd();
                            end
                        end
                        ST_WR_DATA: begin
                            if (rx != last_sent) begin
                                seq_state      = ST_ERR_VERIFY;
                                r.status_valid = 1'b1;
                                r.status       = STS_VERIFY;
                            end else begin
                                byte_count = 16'(byte_count + 16'd1);
                                if (byte_count == xfer_len ||
                                    (int'(byte_count) % PAGE_BYTES) == 0) begin
                                    seq_state = ST_WR_WAIT;
                                    r.cmd     = CMD_STOP_TIMER;
                                end else begin
                                    last_sent  = wbyte;
                                    r.cmd      = CMD_SEND;
                                    r.bus_byte = wbyte;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_STOP_RES: begin
                if (seq_state == ST_RESET_STOP) begin
                    if (bus_free) begin
                        seq_state = ST_IDLE;
                    end else begin
                        seq_state      = ST_ERR_BUS;
                        r.status_valid = 1'b1;
                        r.status       = STS_BUS;
                    end
                end
            end
            OP_TIMER: begin
                if (seq_state == ST_WR_WAIT) begin
                    if (byte_count == xfer_len) begin
                        seq_state      = ST_IDLE;
                        r.cmd          = CMD_STOP;
                        r.status_valid = 1'b1;
                        r.status       = STS_OK;
                    end else begin
                        // next page, address wraps at 16 bits
                        ee_addr    = 16'(ee_addr + PAGE_BYTES);
                        seq_state  = ST_XF_START;
                        r.cmd      = CMD_START;
                        r.bus_byte = ADDR_WRITE;
                    end
                end
            end
            OP_INIT: begin
                seq_state  = ST_RESET_START;
                r.cmd      = CMD_START;
                r.bus_byte = ADDR_RESET;
            end
            default: ;
        endcase
        r.next_index = 16'(byte_count + ((seq_state == ST_WR_DATA) ? 16'd1 : 16'd0));
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            failures++;
            if (failures <= 10)
                $display("result beat %0d: %s mismatch, expected %0h, got %0h",
                         beat_no, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_bus_result want;
        if (!i_rst_n) begin
            seq_state  = ST_INIT;
            byte_count = '0;
            xfer_len   = '0;
            ee_addr    = '0;
            last_sent  = '0;
            writing    = 1'b0;
            for (int i = 0; i < 4; i++) area_base[i] = '0;
            bus_results_due.delete();
        end else begin
            if (i_cfg_we)
                area_base[i_cfg_index] = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                bus_results_due.push_back(sequence_event(i_operation, i_start_ok, i_ack,
                                                         i_rx_byte, i_bus_free, i_area,
                                                         i_length, i_write_byte));
            if (i_out_valid && !i_out_stall) begin
                if (bus_results_due.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("result beat %0d arrived with no event outstanding",
                                 beat_no);
                end else begin
                    want = bus_results_due.pop_front();
                    check_field("bus_command",  16'(want.cmd),          16'(i_bus_command));
                    check_field("bus_byte",     16'(want.bus_byte),     16'(i_bus_byte));
                    check_field("read_valid",   16'(want.read_valid),   16'(i_read_valid));
                    check_field("read_byte",    16'(want.read_byte),    16'(i_read_byte));
                    check_field("read_index",   want.read_index,        i_read_index);
                    check_field("status_valid", 16'(want.status_valid), 16'(i_status_valid));
                    check_field("status",       16'(want.status),       16'(i_status));
                    check_field("next_index",   want.next_index,        i_next_index);
                end
                beat_no++;
            end
        end
        o_pending    <= bus_results_due.size();
        o_fail_count <= failures;
    end

endmodule

// ===== sim/testbench.sv =====
// testbench: reset, area base programming and event stimulus for the EEPROM transfer
// sequencer, with random idling on both channels and a watchdog.
// Depends on i2cee_pkg, i2c_eeprom_transfer_sequencer and i2cee_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cee_pkg::*;

    localparam int         PAGE_BYTES  = 32;
    localparam int         ITEMS       = 1750;
    localparam int         PHASES      = 6;
    localparam int         HOLD_CYCLES = 60;
    localparam int         QUIET_LIMIT = 1000;
    localparam logic [2:0] OP_UNUSED   = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic        start_ok;
        logic        ack;
        logic [7:0]  rx;
        logic        bus_free;
        logic [1:0]  area;
        logic [15:0] len;
        logic [7:0]  wbyte;
    } t_bus_event;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  in_op;
    logic        in_start_ok;
    logic        in_ack;
    logic [7:0]  in_rx;
    logic        in_bus_free;
    logic [1:0]  in_area;
    logic [15:0] in_len;
    logic [7:0]  in_wbyte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  bus_command;
    logic [7:0]  bus_byte;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic [15:0] read_index;
    logic        status_valid;
    logic [2:0]  status;
    logic [15:0] next_index;

    int mismatch_count;
    int results_due;
    int beats_sent;
    int stray_beats;
    int quiet_cycles;
    bit calm;
    bit hold_req;
    bit hold_done;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    i2c_eeprom_transfer_sequencer #(.PAGE_BYTES(PAGE_BYTES)) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (in_op),
        .i_start_ok     (in_start_ok),
        .i_ack          (in_ack),
        .i_rx_byte      (in_rx),
        .i_bus_free     (in_bus_free),
        .i_area         (in_area),
        .i_length       (in_len),
        .i_write_byte   (in_wbyte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_bus_command  (bus_command),
        .o_bus_byte     (bus_byte),
        .o_read_valid   (read_valid),
        .o_read_byte    (read_byte),
        .o_read_index   (read_index),
        .o_status_valid (status_valid),
        .o_status       (status),
        .o_next_index   (next_index)
    );

    i2cee_checker #(.PAGE_BYTES(PAGE_BYTES)) seq_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_operation    (in_op),
        .i_start_ok     (in_start_ok),
        .i_ack          (in_ack),
        .i_rx_byte      (in_rx),
        .i_bus_free     (in_bus_free),
        .i_area         (in_area),
        .i_length       (in_len),
        .i_write_byte   (in_wbyte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_bus_command  (bus_command),
        .i_bus_byte     (bus_byte),
        .i_read_valid   (read_valid),
        .i_read_byte    (read_byte),
        .i_read_index   (read_index),
        .i_status_valid (status_valid),
        .i_status       (status),
        .i_next_index   (next_index),
        .o_fail_count   (mismatch_count),
        .o_pending      (results_due)
    );

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        int burst;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL i2c_eeprom_transfer_sequencer");
            $finish;
        end
    end

    function automatic t_bus_event make_event(input logic [2:0] op);
        t_bus_event ev;
        ev.op       = op;
        ev.start_ok = 1'($urandom_range(0, 1));
        ev.ack      = 1'($urandom_range(0, 1));
        ev.rx       = 8'($urandom_range(0, 255));
        ev.bus_free = 1'($urandom_range(0, 1));
        ev.area     = 2'($urandom_range(0, 3));
        ev.len      = 16'($urandom_range(0, 65535));
        ev.wbyte    = 8'($urandom_range(0, 255));
        return ev;
    endfunction

    function automatic bit fault_roll();
        return $urandom_range(0, 149) == 0;
    endfunction

    task automatic offer_event(input t_bus_event ev);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_op       <= ev.op;
        in_start_ok <= ev.start_ok;
        in_ack      <= ev.ack;
        in_rx       <= ev.rx;
        in_bus_free <= ev.bus_free;
        in_area     <= ev.area;
        in_len      <= ev.len;
        in_wbyte    <= ev.wbyte;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // events that leave the sequencer where it is (or only draw a busy or retry status)
    // while it waits for a byte to finish
    task automatic stray_event();
        t_bus_event ev;
        if ($urandom_range(0, 11) != 0)
            return;
        case ($urandom_range(0, 5))
            0: ev = make_event(OP_READ);
            1: ev = make_event(OP_WRITE);
            2: begin
                ev = make_event(OP_START_RES);
                ev.start_ok = 1'b1;
            end
            3: ev = make_event(OP_STOP_RES);
            4: ev = make_event(OP_TIMER);
            default: ev = make_event(OP_UNUSED);
        endcase
        offer_event(ev);
        stray_beats++;
    endtask

    // drop the offer and wait until every result beat has gone out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_area_bases(input int phase);
        t_reg regs [4];
        regs = '{REG_KEY_AREA, REG_MAIN_AREA, REG_SERVICE_AREA, REG_SCRATCH_AREA};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            case (phase)
                0: cfg_data <= (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                               16'($urandom_range(16'hFFC0, 16'hFFFF));
                1: cfg_data <= 16'hFFFF;
                2: cfg_data <= 16'h0000;
                3: cfg_data <= 16'($urandom_range(16'hFF00, 16'hFFFF));
                default: cfg_data <= 16'($urandom_range(0, 65535));
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic bus_reset(output bit broken);
        t_bus_event ev;
        broken = 1'b1;
        offer_event(make_event(OP_INIT));
        ev = make_event(OP_START_RES);
        ev.start_ok = !fault_roll();
        offer_event(ev);
        if (!ev.start_ok)
            return;
        stray_event();
        offer_event(make_event(OP_BYTE_DONE));
        ev = make_event(OP_STOP_RES);
        ev.bus_free = !fault_roll();
        offer_event(ev);
        broken = !ev.bus_free;
    endtask

    // one read or write; cut below the full length aborts it part way
    task automatic run_transfer(input bit wr, input logic [15:0] len, input int cut,
                                output bit broken);
        t_bus_event ev;
        int         full;
        int         moved;
        logic [7:0] echo;
        full   = (len == 16'd0) ? 65536 : int'(len);
        moved  = 0;
        broken = 1'b1;
        ev = make_event(wr ? OP_WRITE : OP_READ);
        ev.len = len;
        offer_event(ev);
        forever begin
            ev = make_event(OP_START_RES);
            ev.start_ok = !fault_roll();
            offer_event(ev);
            if (!ev.start_ok)
                return;
            // device address then the two address bytes
            for (int k = 0; k < 3; k++) begin
                stray_event();
                ev = make_event(OP_BYTE_DONE);
                ev.ack = !fault_roll();
                offer_event(ev);
                if (!ev.ack)
                    return;
            end
            echo = ev.wbyte;
            if (!wr) begin
                ev = make_event(OP_START_RES);
                ev.start_ok = !fault_roll();
                offer_event(ev);
                if (!ev.start_ok)
                    return;
                ev = make_event(OP_BYTE_DONE);
                ev.ack = !fault_roll();
                offer_event(ev);
                if (!ev.ack)
                    return;
                for (int i = 0; i < cut; i++) begin
                    stray_event();
                    offer_event(make_event(OP_BYTE_DONE));
                end
                broken = (cut < full);
                return;
            end
            do begin
                stray_event();
                ev = make_event(OP_BYTE_DONE);
                ev.ack = !fault_roll();
                ev.rx  = fault_roll() ? echo ^ 8'($urandom_range(1, 255)) : echo;
                offer_event(ev);
                if (!ev.ack || ev.rx != echo)
                    return;
                echo = ev.wbyte;
                moved++;
                if (moved == cut && cut < full)
                    return;
            end while ((moved % PAGE_BYTES) != 0 && moved != full);
            offer_event(make_event(OP_TIMER));
            if (moved == full) begin
                broken = 1'b0;
                return;
            end
        end
    endtask

    initial begin : stimulus
        t_bus_event  ev;
        bit          need_reset;
        int          phase;
        int          next_phase;
        int          pick;
        int          full;
        logic [15:0] len;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        in_op       <= '0;
        in_start_ok <= 1'b0;
        in_ack      <= 1'b0;
        in_rx       <= '0;
        in_bus_free <= 1'b0;
        in_area     <= '0;
        in_len      <= '0;
        in_wbyte    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        load_area_bases(0);

        // directed: requests before the bus reset, odd events, both reset failures
        ev = make_event(OP_READ);
        ev.area = 2'd3;
        ev.len  = 16'hFFFF;
        offer_event(ev);
        offer_event(make_event(OP_UNUSED));
        offer_event(make_event(OP_TIMER));
        offer_event(make_event(OP_INIT));
        ev = make_event(OP_WRITE);
        ev.area = 2'd0;
        ev.len  = 16'h0000;
        offer_event(ev);
        ev = make_event(OP_START_RES);
        ev.start_ok = 1'b1;
        offer_event(ev);
        offer_event(make_event(OP_BYTE_DONE));
        offer_event(make_event(OP_READ));
        ev = make_event(OP_STOP_RES);
        ev.bus_free = 1'b0;
        offer_event(ev);
        offer_event(make_event(OP_WRITE));
        offer_event(make_event(OP_BYTE_DONE));
        offer_event(make_event(OP_INIT));
        ev = make_event(OP_START_RES);
        ev.start_ok = 1'b0;
        offer_event(ev);
        offer_event(make_event(OP_READ));
        offer_event(make_event(OP_INIT));
        offer_event(make_event(OP_BYTE_DONE));
        ev = make_event(OP_STOP_RES);
        ev.bus_free = 1'b1;
        offer_event(ev);

        // long result hold-off with events offered back to back
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (8) offer_event(make_event(OP_UNUSED));
        calm = 1'b0;

        need_reset = 1'b0;
        phase      = 0;
        while (beats_sent - stray_beats < ITEMS) begin
            next_phase = (beats_sent - stray_beats) * PHASES / ITEMS;
            if (next_phase != phase) begin
                phase = next_phase;
                settle();
                load_area_bases(phase);
                calm = (phase == PHASES - 1);
            end
            if (need_reset) begin
                // a request here answers with the latched error, or busy after an abort
                if ($urandom_range(0, 1) == 0)
                    offer_event(make_event($urandom_range(0, 1) ? OP_WRITE : OP_READ));
                bus_reset(need_reset);
            end else begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0:       len = 16'h0000;
                    1:       len = 16'hFFFF;
                    2:       len = 16'($urandom_range(0, 65535));
                    3, 4, 5, 6, 7: len = 16'($urandom_range(1, 3));
                    default: len = 16'($urandom_range(1, 80));
                endcase
                full = (len == 16'd0) ? 65536 : int'(len);
                run_transfer(1'($urandom_range(0, 1)), len,
                             (full > 100) ? int'($urandom_range(1, 40)) : full, need_reset);
            end
        end

        settle();
        if (mismatch_count == 0 && results_due == 0)
            $display("PASS i2c_eeprom_transfer_sequencer");
        else
            $display("FAIL i2c_eeprom_transfer_sequencer");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/i2cee_pkg.sv
rtl/i2c_eeprom_transfer_sequencer.sv
rtl/i2cee_checker.sv
sim/i2cee_checker.sv
sim/testbench.sv
